[src/oqls_pkg.sv]
`timescale 1ns / 1ps

package oqls_pkg;

    localparam int PAGE_W   = 32;
    localparam int LEVEL_W  = 5;
    localparam int ENTRY_W  = PAGE_W + LEVEL_W;
    localparam int POS_W    = 6;
    localparam int QCOUNT_W = 7;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 3'd0,
        OP_ENQ   = 3'd1,
        OP_DEQ   = 3'd2,
        OP_RM2   = 3'd3,
        OP_RMPOS = 3'd4,
        OP_SRCH  = 3'd5,
        OP_PEEK  = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NO_SECOND = 3'd3,
        ST_BAD_POS   = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        A_NONE,
        A_CLEAR,
        A_ENQ,
        A_FAIL,
        A_NOP,
        A_RM_START,
        A_SHIFT,
        A_SRCH_START,
        A_SRCH,
        A_PEEK_START,
        A_PEEK
    } t_act;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SHIFT,
        S_SRCH,
        S_PEEK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [LEVEL_W-1:0] level;
    } t_entry;

    typedef struct packed {
        logic    load;
        t_act    act;
        t_status code;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic one_left;
        logic pos_bad;
        logic shift_last;
        logic hit;
        logic chk_zero;
        logic out_free;
    } t_stat;

endpackage

[src/oqls_ram.sv]
`timescale 1ns / 1ps

module oqls_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/oqls_ctrl.sv]
`timescale 1ns / 1ps

module oqls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  oqls_pkg::t_stat i_stat,
    output oqls_pkg::t_cmd  o_cmd
);

    oqls_pkg::t_state r_state;
    oqls_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oqls_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            oqls_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = oqls_pkg::S_EVAL;
                end
            end
            oqls_pkg::S_EVAL: begin
                n_state = oqls_pkg::S_DONE;
                case (i_stat.op)
                    oqls_pkg::OP_DEQ: begin
                        if (!i_stat.empty) begin
                            n_state = oqls_pkg::S_SHIFT;
                        end
                    end
                    oqls_pkg::OP_RM2: begin
                        if (!i_stat.empty && !i_stat.one_left) begin
                            n_state = oqls_pkg::S_SHIFT;
                        end
                    end
                    oqls_pkg::OP_RMPOS: begin
                        if (!i_stat.empty && !i_stat.pos_bad) begin
                            n_state = oqls_pkg::S_SHIFT;
                        end
                    end
                    oqls_pkg::OP_SRCH: begin
                        if (!i_stat.empty) begin
                            n_state = oqls_pkg::S_SRCH;
                        end
                    end
                    oqls_pkg::OP_PEEK: begin
                        if (!i_stat.empty) begin
                            n_state = oqls_pkg::S_PEEK;
                        end
                    end
                    default: begin
                        n_state = oqls_pkg::S_DONE;
                    end
                endcase
            end
            oqls_pkg::S_SHIFT: begin
                if (i_stat.shift_last) begin
                    n_state = oqls_pkg::S_DONE;
                end
            end
            oqls_pkg::S_SRCH: begin
                if (i_stat.hit || i_stat.chk_zero) begin
                    n_state = oqls_pkg::S_DONE;
                end
            end
            oqls_pkg::S_PEEK: begin
                n_state = oqls_pkg::S_DONE;
            end
            oqls_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = oqls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oqls_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '{load: 1'b0, act: oqls_pkg::A_NONE, code: oqls_pkg::ST_OK, emit: 1'b0};
        o_in_stall = 1'b1;
        case (r_state)
            oqls_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            oqls_pkg::S_EVAL: begin
                case (i_stat.op)
                    oqls_pkg::OP_CLEAR: begin
                        o_cmd.act = oqls_pkg::A_CLEAR;
                    end
                    oqls_pkg::OP_ENQ: begin
                        if (i_stat.full) begin
                            o_cmd.act  = oqls_pkg::A_FAIL;
                            o_cmd.code = oqls_pkg::ST_FULL;
                        end else begin
                            o_cmd.act = oqls_pkg::A_ENQ;
                        end
                    end
                    oqls_pkg::OP_DEQ: begin
                        if (i_stat.empty) begin
                            o_cmd.act  = oqls_pkg::A_FAIL;
                            o_cmd.code = oqls_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.act = oqls_pkg::A_RM_START;
                        end
                    end
                    oqls_pkg::OP_RM2: begin
                        if (i_stat.empty) begin
                            o_cmd.act  = oqls_pkg::A_FAIL;
                            o_cmd.code = oqls_pkg::ST_EMPTY;
                        end else if (i_stat.one_left) begin
                            o_cmd.act  = oqls_pkg::A_FAIL;
                            o_cmd.code = oqls_pkg::ST_NO_SECOND;
                        end else begin
                            o_cmd.act = oqls_pkg::A_RM_START;
                        end
                    end
                    oqls_pkg::OP_RMPOS: begin
                        if (i_stat.empty) begin
                            o_cmd.act  = oqls_pkg::A_FAIL;
                            o_cmd.code = oqls_pkg::ST_EMPTY;
                        end else if (i_stat.pos_bad) begin
                            o_cmd.act  = oqls_pkg::A_FAIL;
                            o_cmd.code = oqls_pkg::ST_BAD_POS;
                        end else begin
                            o_cmd.act = oqls_pkg::A_RM_START;
                        end
                    end
                    oqls_pkg::OP_SRCH: begin
                        if (i_stat.empty) begin
                            o_cmd.act  = oqls_pkg::A_FAIL;
                            o_cmd.code = oqls_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.act = oqls_pkg::A_SRCH_START;
                        end
                    end
                    oqls_pkg::OP_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.act  = oqls_pkg::A_FAIL;
                            o_cmd.code = oqls_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.act = oqls_pkg::A_PEEK_START;
                        end
                    end
                    default: begin
                        o_cmd.act = oqls_pkg::A_NOP;
                    end
                endcase
            end
            oqls_pkg::S_SHIFT: begin
                o_cmd.act = oqls_pkg::A_SHIFT;
            end
            oqls_pkg::S_SRCH: begin
                o_cmd.act = oqls_pkg::A_SRCH;
            end
            oqls_pkg::S_PEEK: begin
                o_cmd.act = oqls_pkg::A_PEEK;
            end
            oqls_pkg::S_DONE: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

[src/oqls_dp.sv]
`timescale 1ns / 1ps

module oqls_dp #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  oqls_pkg::t_cmd                    i_cmd,
    output oqls_pkg::t_stat                   o_stat,
    input  logic [oqls_pkg::OP_W-1:0]         i_operation,
    input  logic [oqls_pkg::PAGE_W-1:0]       i_entry_page,
    input  logic [oqls_pkg::LEVEL_W-1:0]      i_entry_level,
    input  logic [oqls_pkg::POS_W-1:0]        i_position,
    input  logic [oqls_pkg::LEVEL_W-1:0]      i_search_level,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [oqls_pkg::STATUS_W-1:0]     o_status,
    output logic [oqls_pkg::PAGE_W-1:0]       o_found_page,
    output logic [oqls_pkg::LEVEL_W-1:0]      o_found_level,
    output logic [oqls_pkg::POS_W-1:0]        o_found_position,
    output logic [oqls_pkg::QCOUNT_W-1:0]     o_queue_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int PW = (CW > oqls_pkg::POS_W) ? CW : oqls_pkg::POS_W;

    oqls_pkg::t_op                r_op;
    logic [oqls_pkg::PAGE_W-1:0]  r_page;
    logic [oqls_pkg::LEVEL_W-1:0] r_level;
    logic [oqls_pkg::POS_W-1:0]   r_pos;
    logic [oqls_pkg::LEVEL_W-1:0] r_slevel;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_chk;
    logic          r_first;

    oqls_pkg::t_status            r_w_status;
    logic [oqls_pkg::PAGE_W-1:0]  r_w_page;
    logic [oqls_pkg::LEVEL_W-1:0] r_w_level;
    logic [CW-1:0]                r_w_where;

    logic                              r_o_vld;
    oqls_pkg::t_status                 r_o_status;
    logic [oqls_pkg::PAGE_W-1:0]       r_o_page;
    logic [oqls_pkg::LEVEL_W-1:0]      r_o_level;
    logic [oqls_pkg::POS_W-1:0]        r_o_where;
    logic [oqls_pkg::QCOUNT_W-1:0]     r_o_count;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [oqls_pkg::ENTRY_W-1:0] wdata;
    logic                        re;
    logic [AW-1:0]               raddr;
    logic [oqls_pkg::ENTRY_W-1:0] rdata_raw;
    oqls_pkg::t_entry            rdata;
    logic [CW-1:0]               rm_idx;
    logic                        shift_last;
    logic                        hit;
    logic                        chk_zero;

    oqls_ram #(
        .WIDTH (oqls_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    assign rdata      = oqls_pkg::t_entry'(rdata_raw);
    assign shift_last = (r_ptr == r_count);
    assign hit        = (rdata.level == r_slevel);
    assign chk_zero   = (r_chk == '0);

    always_comb begin
        case (r_op)
            oqls_pkg::OP_DEQ: rm_idx = '0;
            oqls_pkg::OP_RM2: rm_idx = CW'(1);
            default:          rm_idx = CW'(r_pos);
        endcase
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count == CW'(QUEUE_DEPTH));
        o_stat.one_left   = (r_count < CW'(2));
        o_stat.pos_bad    = (PW'(r_pos) >= PW'(r_count));
        o_stat.shift_last = shift_last;
        o_stat.hit        = hit;
        o_stat.chk_zero   = chk_zero;
        o_stat.out_free   = !r_o_vld || !i_out_stall;
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = '0;
        case (i_cmd.act)
            oqls_pkg::A_ENQ: begin
                we    = 1'b1;
                waddr = AW'(r_count);
                wdata = {r_page, r_level};
            end
            oqls_pkg::A_RM_START: begin
                re    = 1'b1;
                raddr = AW'(rm_idx);
            end
            oqls_pkg::A_SHIFT: begin
                if (!r_first) begin
                    we    = 1'b1;
                    waddr = AW'(r_ptr - CW'(2));
                    wdata = rdata_raw;
                end
                if (!shift_last) begin
                    re    = 1'b1;
                    raddr = AW'(r_ptr);
                end
            end
            oqls_pkg::A_SRCH_START: begin
                re    = 1'b1;
                raddr = AW'(r_count - CW'(1));
            end
            oqls_pkg::A_SRCH: begin
                if (!hit && !chk_zero) begin
                    re    = 1'b1;
                    raddr = AW'(r_chk - CW'(1));
                end
            end
            oqls_pkg::A_PEEK_START: begin
                re    = 1'b1;
                raddr = '0;
            end
            default: begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= oqls_pkg::t_op'(i_operation);
            r_page   <= i_entry_page;
            r_level  <= i_entry_level;
            r_pos    <= i_position;
            r_slevel <= i_search_level;
        end

        case (i_cmd.act)
            oqls_pkg::A_CLEAR, oqls_pkg::A_NOP: begin
                r_w_status <= oqls_pkg::ST_OK;
                r_w_page   <= '0;
                r_w_level  <= '0;
                r_w_where  <= '0;
            end
            oqls_pkg::A_FAIL: begin
                r_w_status <= i_cmd.code;
                r_w_page   <= '0;
                r_w_level  <= '0;
                r_w_where  <= '0;
            end
            oqls_pkg::A_ENQ: begin
                r_w_status <= oqls_pkg::ST_OK;
                r_w_page   <= r_page;
                r_w_level  <= r_level;
                r_w_where  <= r_count;
            end
            oqls_pkg::A_RM_START: begin
                r_w_status <= oqls_pkg::ST_OK;
                r_w_where  <= rm_idx;
                r_ptr      <= rm_idx + CW'(1);
                r_first    <= 1'b1;
            end
            oqls_pkg::A_SHIFT: begin
                r_first <= 1'b0;
                if (r_first) begin
                    r_w_page  <= rdata.page;
                    r_w_level <= rdata.level;
                end
                if (!shift_last) begin
                    r_ptr <= r_ptr + CW'(1);
                end
            end
            oqls_pkg::A_SRCH_START: begin
                r_chk <= r_count - CW'(1);
            end
            oqls_pkg::A_SRCH: begin
                if (hit) begin
                    r_w_status <= oqls_pkg::ST_OK;
                    r_w_page   <= rdata.page;
                    r_w_level  <= rdata.level;
                    r_w_where  <= r_chk;
                end else if (chk_zero) begin
                    r_w_status <= oqls_pkg::ST_NOT_FOUND;
                    r_w_page   <= '0;
                    r_w_level  <= '0;
                    r_w_where  <= '0;
                end else begin
                    r_chk <= r_chk - CW'(1);
                end
            end
            oqls_pkg::A_PEEK_START: begin
                r_w_status <= oqls_pkg::ST_OK;
                r_w_where  <= '0;
            end
            oqls_pkg::A_PEEK: begin
                r_w_page  <= rdata.page;
                r_w_level <= rdata.level;
            end
            default: begin
                r_first <= r_first;
            end
        endcase

        if (i_cmd.emit) begin
            r_o_status <= r_w_status;
            r_o_page   <= r_w_page;
            r_o_level  <= r_w_level;
            r_o_where  <= oqls_pkg::POS_W'(r_w_where);
            r_o_count  <= oqls_pkg::QCOUNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_o_vld <= 1'b0;
        end else begin
            case (i_cmd.act)
                oqls_pkg::A_CLEAR: r_count <= '0;
                oqls_pkg::A_ENQ:   r_count <= r_count + CW'(1);
                oqls_pkg::A_SHIFT: begin
                    if (shift_last) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                default: r_count <= r_count;
            endcase
            if (i_cmd.emit) begin
                r_o_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_status         = r_o_status;
    assign o_found_page     = r_o_page;
    assign o_found_level    = r_o_level;
    assign o_found_position = r_o_where;
    assign o_queue_count    = r_o_count;

endmodule

[src/ordered_queue_with_level_search.sv]
`timescale 1ns / 1ps

// Ordered queue of (page, level) entries held in a single-port-read RAM with the head at
// address 0. Each request yields one result. Clear, enqueue, undefined operations and
// refused requests are settled in the evaluation state; a peek reads the head first.
// Removing the entry at position p from a queue of n entries moves every later entry up
// one address per cycle through the RAM's one read and one write port. A search reads
// one entry per cycle from the tail and stops at the first level match or after the head,
// examining up to n entries. A new request is taken while a finished result waits
// in the output register. No clearing pass is needed after reset.
module ordered_queue_with_level_search #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [oqls_pkg::OP_W-1:0]     i_operation,
    input  logic [oqls_pkg::PAGE_W-1:0]   i_entry_page,
    input  logic [oqls_pkg::LEVEL_W-1:0]  i_entry_level,
    input  logic [oqls_pkg::POS_W-1:0]    i_position,
    input  logic [oqls_pkg::LEVEL_W-1:0]  i_search_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [oqls_pkg::STATUS_W-1:0] o_status,
    output logic [oqls_pkg::PAGE_W-1:0]   o_found_page,
    output logic [oqls_pkg::LEVEL_W-1:0]  o_found_level,
    output logic [oqls_pkg::POS_W-1:0]    o_found_position,
    output logic [oqls_pkg::QCOUNT_W-1:0] o_queue_count
);

    oqls_pkg::t_cmd  cmd;
    oqls_pkg::t_stat stat;

    oqls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    oqls_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_entry_page     (i_entry_page),
        .i_entry_level    (i_entry_level),
        .i_position       (i_position),
        .i_search_level   (i_search_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_page     (o_found_page),
        .o_found_level    (o_found_level),
        .o_found_position (o_found_position),
        .o_queue_count    (o_queue_count)
    );

endmodule
